// File: src/lbd_pkg.sv
// Package for the ladder button decoder: field widths, key windows and classifier.
package lbd_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int NOW_W     = 32;
  localparam int KEY_W     = 4;
  localparam int DELAY_W   = 16;
  localparam int NUM_KEYS  = 8;
  localparam int TIME_BITS_DEF = 32;

  // APB register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DEBOUNCE_DELAY = 1'b0;  // selected by paddr[2]

  localparam logic [DELAY_W-1:0]  DELAY_RESET = 16'd50;
  localparam logic [SAMPLE_W-1:0] START_LIMIT = 10'd1000;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [KEY_W-1:0]    key_t;

  localparam key_t KEY_NONE = 4'd0;

  // Open key windows on the averaged ladder reading
  localparam sample_t WIN_LOW  [NUM_KEYS] = '{10'd145, 10'd260, 10'd420, 10'd585,
                                              10'd715, 10'd820, 10'd915, 10'd960};
  localparam sample_t WIN_HIGH [NUM_KEYS] = '{10'd185, 10'd290, 10'd450, 10'd615,
                                              10'd745, 10'd850, 10'd945, 10'd1000};

  // Map an averaged reading to key 1..8, or KEY_NONE outside every window
  function automatic key_t classify(input sample_t avg);
    key_t k;
    k = KEY_NONE;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (avg > WIN_LOW[i] && avg < WIN_HIGH[i]) begin
        k = KEY_W'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

// File: src/ladder_button_decoder_top.sv
// Top level of the ladder button decoder: input stage, debounce state, result register.
// Ladder button decoder. Each input beat carries a 10-bit ADC sample of the
// resistor-ladder line (tdata[9:0]) and a millisecond timestamp (tdata[41:10]).
// A reading below 1000 while idle starts a debounce wait; once debounce_delay ms
// have passed, a matching confirm sample updates the average, which is mapped to
// key 1..8. Every input beat yields exactly one output beat with the debounced key
// (tdata[3:0], 0 while waiting or no key) and the key released on this beat
// (tdata[7:4]), one beat per clock while the result side is not stalled, through the
// input and result registers. debounce_delay sits at APB byte address 0 (reset 50); it
// must be written only while idle, which the block itself does not enforce.
module ladder_button_decoder_top
  import lbd_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // [9:0] sample, [41:10] now_ms, [47:42] zero
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [3:0] key_code, [7:4] released_key
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int EXT_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

  typedef logic [TIME_BITS-1:0] time_t;

  // configuration register
  logic [DELAY_W-1:0] delay_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (cfg_paddr[2] == REG_DEBOUNCE_DELAY);
  assign cfg_prdata = (cfg_paddr[2] == REG_DEBOUNCE_DELAY) ?
                      CFG_DATA_W'(delay_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_wr) begin
      delay_r <= cfg_pwdata[DELAY_W-1:0];
    end
  end

  // pipeline control
  logic s1_valid_r;
  logic advance;

  assign advance   = s1_valid_r & (~out_tvalid | out_tready);
  assign in_tready = ~s1_valid_r | advance;

  // input register
  sample_t         s1_sample_r;
  logic [NOW_W-1:0] s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
      s1_now_r    <= in_tdata[SAMPLE_W +: NOW_W];
    end
  end

  // debounce state
  logic    checking_r, checking_nxt;
  time_t   start_r, start_nxt;
  sample_t first_r, first_nxt;
  sample_t avg_r, avg_nxt;
  key_t    prev_key_r;

  logic [EXT_W-1:0] now_ext;
  time_t   now_t, elapsed;
  logic    idle, arm, chk, done;
  key_t    key, rel;

  // one debounce step on the item in the input register
  always_comb begin
    now_ext   = EXT_W'(s1_now_r);
    now_t     = now_ext[TIME_BITS-1:0];
    idle      = ~checking_r;
    arm       = idle & (s1_sample_r < START_LIMIT);
    first_nxt = idle ? s1_sample_r : first_r;
    chk       = ~idle | arm;
    start_nxt = arm ? now_t : start_r;
    elapsed   = now_t - start_nxt;
    done      = chk & (elapsed >= TIME_BITS'(delay_r));
    avg_nxt   = (done && s1_sample_r == first_nxt) ? s1_sample_r : avg_r;
    key       = done ? classify(avg_nxt) : KEY_NONE;
    checking_nxt = chk & ~done;
    rel       = (key == KEY_NONE && prev_key_r != KEY_NONE) ? prev_key_r : KEY_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checking_r <= 1'b0;
      start_r    <= '0;
      first_r    <= '0;
      avg_r      <= '0;
      prev_key_r <= KEY_NONE;
    end else if (advance) begin
      checking_r <= checking_nxt;
      start_r    <= start_nxt;
      first_r    <= first_nxt;
      avg_r      <= avg_nxt;
      prev_key_r <= key;
    end
  end

  // result register
  logic out_valid_r;
  key_t out_key_r, out_rel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_key_r <= key;
      out_rel_r <= rel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rel_r, out_key_r};

`ifndef ASSERT_OFF
  // a beat never reports a key press and a release together
  a_key_or_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_key_r == KEY_NONE || out_rel_r == KEY_NONE))
    else $error("key and release reported on the same beat");

  // the remembered key tracks the last key sent out
  a_prev_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (prev_key_r == out_key_r))
    else $error("previous key out of step with result register");

  // a wait is only ever armed by a reading below the start limit
  a_wait_armed: assert property (@(posedge clk) disable iff (!rst_n)
    checking_r |-> (first_r < START_LIMIT))
    else $error("debounce wait running on an out-of-range first sample");

  // keys stay inside 0..8
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_key_r <= KEY_W'(NUM_KEYS) && out_rel_r <= KEY_W'(NUM_KEYS)))
    else $error("key code out of range");
`endif

endmodule

// File: test/tb_top.sv
// Testbench for the ladder button decoder: key prediction checked beat by beat under random flow.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lbd_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_ITEMS = 85;
  localparam int PRESS_LEVEL = 1000;
  // open key windows, key i+1 strictly between KEY_LO[i] and KEY_HI[i]
  localparam int KEY_LO [8] = '{145, 260, 420, 585, 715, 820, 915, 960};
  localparam int KEY_HI [8] = '{185, 290, 450, 615, 745, 850, 945, 1000};

  typedef struct packed {
    key_t key;
    key_t rel;
  } key_pair_t;

  // Tracks the debounce state and the key pairs still owed by the block
  class keypad_tracker;
    logic [DELAY_W-1:0] delay_ms;
    bit                 armed;
    logic [31:0]        t_start;
    sample_t            first_smp;
    sample_t            avg_smp;
    key_t               last_key;
    key_pair_t          due[$];
    int                 fails;

    function new();
      delay_ms  = 16'd50;
      armed     = 1'b0;
      t_start   = '0;
      first_smp = '0;
      avg_smp   = '0;
      last_key  = KEY_NONE;
      fails     = 0;
    endfunction

    function void note_fail(string msg);
      fails++;
      if (fails <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function key_t window_key(sample_t a);
      for (int i = 0; i < 8; i++) begin
        if (int'(a) > KEY_LO[i] && int'(a) < KEY_HI[i]) begin
          return key_t'(i + 1);
        end
      end
      return KEY_NONE;
    endfunction

    // accepted input beat: advance the debounce state, queue the key pair it yields
    function void take_sample(sample_t smp, logic [31:0] now);
      key_pair_t   p;
      logic [31:0] elapsed;
      p.key = KEY_NONE;
      p.rel = KEY_NONE;
      if (!armed) begin
        first_smp = smp;
        if (int'(smp) < PRESS_LEVEL) begin
          armed   = 1'b1;
          t_start = now;
        end
      end
      elapsed = now - t_start;  // wraps modulo 2^32
      if (armed && elapsed >= {16'd0, delay_ms}) begin
        if (smp == first_smp) begin
          avg_smp = smp;
        end
        armed = 1'b0;
        p.key = window_key(avg_smp);
      end
      if (p.key == KEY_NONE && last_key != KEY_NONE) begin
        p.rel = last_key;
      end
      last_key = p.key;
      due.push_back(p);
    endfunction

    // accepted result beat: compare against the oldest owed pair
    function void match_result(key_t k, key_t r);
      key_pair_t p;
      if (due.size() == 0) begin
        note_fail($sformatf("unexpected result: key_code=%0d released_key=%0d", k, r));
        return;
      end
      p = due.pop_front();
      if (k !== p.key) begin
        note_fail($sformatf("key_code mismatch: expected %0d, got %0d", p.key, k));
      end
      if (r !== p.rel) begin
        note_fail($sformatf("released_key mismatch: expected %0d, got %0d", p.rel, r));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [47:0]           in_tdata = '0;   // [9:0] sample, [41:10] now_ms, [47:42] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [3:0] key_code, [7:4] released_key
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  keypad_tracker tracker = new();
  bit            no_gaps = 1'b0;
  bit            hold_req = 1'b0;
  int            sent = 0;
  int            quiet = 0;
  logic [31:0]   ms_now = '0;

  ladder_button_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: end the run if no beat or register access moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one input beat after a random gap; with no gap, valid stays high into the next beat
  task automatic send_beat(input sample_t smp, input logic [31:0] now);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, now, smp};
    do @(posedge clk); while (!in_tready);
    tracker.take_sample(smp, now);
    sent++;
  endtask

  // Stop offering and wait until every owed result is back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write of the debounce delay: setup phase, then access phase
  task automatic cfg_write(input logic [DELAY_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_DEBOUNCE_DELAY, 2'b00};
    cfg_pwdata  <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.delay_ms = val;
  endtask

  // Stray reading at a random or nearby time
  task automatic noise_beat();
    if ($urandom_range(0, 3) == 0) begin
      ms_now = $urandom();
    end else begin
      ms_now += $urandom_range(0, 100);
    end
    send_beat(sample_t'($urandom_range(0, 1023)), ms_now);
  endtask

  // Press: first reading, some readings inside the wait, confirm, then release readings
  task automatic press_sequence();
    sample_t     smp;
    sample_t     confirm;
    logic [31:0] t0;
    logic [31:0] extra;
    int          w;
    int          d;
    if ($urandom_range(0, 9) == 0) begin
      ms_now = $urandom();
    end else begin
      ms_now += $urandom_range(1, 200);
    end
    t0 = ms_now;
    d  = tracker.delay_ms;
    w  = $urandom_range(0, 7);
    if ($urandom_range(0, 4) != 0) begin
      smp = sample_t'($urandom_range(KEY_LO[w] + 1, KEY_HI[w] - 1));
    end else begin
      smp = sample_t'($urandom_range(0, PRESS_LEVEL - 1));
    end
    send_beat(smp, t0);
    if (d > 0) begin
      repeat ($urandom_range(0, 3)) begin
        send_beat(sample_t'($urandom_range(0, 1023)), t0 + $urandom_range(0, d - 1));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      extra = $urandom_range(0, 32'h7FFF_FFFF);
    end else begin
      extra = $urandom_range(0, 20);
    end
    confirm = ($urandom_range(0, 6) != 0) ? smp : sample_t'($urandom_range(0, 1023));
    ms_now = t0 + d + extra;
    send_beat(confirm, ms_now);
    repeat ($urandom_range(0, 2)) begin
      ms_now += $urandom_range(1, 30);
      send_beat(sample_t'($urandom_range(PRESS_LEVEL, 1023)), ms_now);
    end
  endtask

  // Result side: random ready gaps, one long hold on request
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.match_result(out_tdata[3:0], out_tdata[7:4]);
    end
  end

  // Stimulus sequence
  initial begin
    int               goal;
    logic [DELAY_W-1:0] dly;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle readings at and above the press level, then a press across the time wrap
    send_beat(10'd1023, 32'd0);
    send_beat(10'd1000, 32'hFFFF_FFFF);
    send_beat(10'd999,  32'hFFFF_FFF0);
    send_beat(10'd999,  32'h0000_0021);   // 49 ms after start: still waiting
    send_beat(10'd999,  32'h0000_0022);   // 50 ms: key 8 confirmed
    send_beat(10'd1023, 32'h0000_0030);   // key 8 released

    // zero delay: confirm in the same beat, every upper window edge and values just inside
    settle();
    cfg_write(16'd0);
    send_beat(10'd0, 32'h0000_0100);
    send_beat(sample_t'(KEY_LO[0]), 32'h0000_0101);
    for (int i = 0; i < 8; i++) begin
      send_beat(sample_t'(KEY_LO[i] + 1), 32'h0000_0110 + i);
      send_beat(sample_t'(KEY_HI[i]), 32'h0000_0120 + i);
    end

    // confirm differs from the first reading: old average is kept
    settle();
    cfg_write(16'd2);
    send_beat(10'd280, 32'h0000_0200);
    send_beat(10'd700, 32'h0000_0202);
    ms_now = 32'h0000_0300;

    // random phases over several delay settings
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          dly = 16'd3;
        end
        1: begin
          dly = 16'hFFFF;
        end
        2: begin
          dly = 16'd0;
        end
        3: begin
          dly = 16'd1;
        end
        4: begin
          dly = 16'($urandom_range(0, 16'hFFFF));
        end
        default: begin
          dly = 16'd50;
        end
      endcase
      cfg_write(dly);
      no_gaps = (ph == 2 || ph == 4);
      if (ph == 2) begin
        hold_req = 1'b1;  // receiver stalls while the sender keeps offering
      end
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        if ($urandom_range(0, 4) == 0) begin
          noise_beat();
        end else begin
          press_sequence();
        end
      end
    end
    no_gaps = 1'b0;

    // drain
    settle();
    repeat (8) @(posedge clk);
    if (tracker.due.size() != 0) begin
      tracker.note_fail($sformatf("%0d results never arrived", tracker.due.size()));
    end
    if (tracker.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: ladder_button_decoder_top.f
src/lbd_pkg.sv
src/ladder_button_decoder_top.sv
test/tb_top.sv
